// ===== src/rci_pkg.sv =====
package rci_pkg;

  // configuration register geometry
  localparam int CFG_W = 13;
  localparam int IDX_W = 2;

  // payload widths fixed by the interface
  localparam int SAMPLE_W = 32;
  localparam int OUT_W    = 32;
  localparam int STATUS_W = 2;

  // defaults for the top level parameters
  localparam int DEF_MAX_ITEMS  = 4096;
  localparam int DEF_DATA_WIDTH = 32;

  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [CFG_W-1:0]    cfg_word_t;
  typedef logic [IDX_W-1:0]    cfg_idx_t;

  // register indexes
  localparam cfg_idx_t REG_FRAME_LENGTH = 2'd0;
  localparam cfg_idx_t REG_BLOCK_SIZE   = 2'd1;
  localparam cfg_idx_t REG_DIRECTION    = 2'd2;

  // register reset values
  localparam cfg_word_t RST_FRAME_LENGTH = 13'd4096;
  localparam cfg_word_t RST_BLOCK_SIZE   = 13'd64;
  localparam logic      DIR_INTERLEAVE   = 1'b0;
  localparam logic      DIR_DEINTERLEAVE = 1'b1;

  // item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // result status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NOT_FULL = 2'd1;
  localparam status_t ST_FULL     = 2'd2;

endpackage

// ===== src/rci_if.sv =====
interface rci_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [rci_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink   (input valid, input op, input sample, output ready);
endinterface

interface rci_out_if;
  logic                       valid;
  logic                       ready;
  logic [rci_pkg::OUT_W-1:0]  data_out;
  logic                       last;
  rci_pkg::status_t           status;

  modport source (output valid, output data_out, output last, output status, input ready);
  modport sink   (input valid, input data_out, input last, input status, output ready);
endinterface

// ===== src/rci_div.sv =====
module rci_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rci_pkg::CFG_W-1:0] dividend,
  input  logic [rci_pkg::CFG_W-1:0] divisor,
  output logic                      busy,
  output logic [rci_pkg::CFG_W-1:0] quot,
  output logic [rci_pkg::CFG_W-1:0] rem
);
  import rci_pkg::*;

  localparam int STEP_W = $clog2(CFG_W + 1);

  logic [STEP_W-1:0] cnt;
  logic [CFG_W-1:0]  acc;   // dividend bits shift out, quotient bits shift in
  logic [CFG_W-1:0]  rem_r;
  logic [CFG_W-1:0]  dsor;
  logic [CFG_W:0]    trial;
  logic [CFG_W:0]    diff;
  logic              ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_r, acc[CFG_W-1]};
    diff  = trial - {1'b0, dsor};
    ge    = (trial >= {1'b0, dsor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      cnt   <= '0;
      acc   <= '0;
      rem_r <= '0;
      dsor  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      cnt   <= STEP_W'(CFG_W);
      acc   <= dividend;
      rem_r <= '0;
      dsor  <= divisor;
    end else if (busy) begin
      rem_r <= ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
      acc   <= {acc[CFG_W-2:0], ge};
      cnt   <= cnt - STEP_W'(1);
      busy  <= (cnt != STEP_W'(1));
    end
  end

  assign quot = acc;
  assign rem  = rem_r;

endmodule

// ===== src/rci_buf.sv =====
module rci_buf #(
  parameter int AW = 12,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] q
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      q <= mem[raddr];
    end
  end

endmodule

// ===== src/row_column_block_interleaver.sv =====
// A fetch word (or an error word) shows on results in the cycle after it is accepted.
// Throughput: one word per cycle, load or fetch, unless results stall or the divider runs.
// After reset and after any write to a listed register, block_count is rebuilt by a
// bit-serial divider: items are held off while it runs.
// Reset: registers to defaults, frame counters cleared; the frame buffer is not cleared.
module row_column_block_interleaver #(
  parameter int MAX_ITEMS  = rci_pkg::DEF_MAX_ITEMS,
  parameter int DATA_WIDTH = rci_pkg::DEF_DATA_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  rci_in_if.sink                    items,
  rci_out_if.source                 results,
  input  logic                      cfg_we,
  input  logic [rci_pkg::IDX_W-1:0] cfg_index,
  input  logic [rci_pkg::CFG_W-1:0] cfg_data
);
  import rci_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);        // buffer address
  localparam int CW = $clog2(MAX_ITEMS + 1);    // counts up to a full frame
  localparam int XW = ((CW > CFG_W) ? CW : CFG_W) + 1;

  // configuration registers
  cfg_word_t frame_length;
  cfg_word_t row_size;
  logic      direction;
  logic      cfg_hit;

  // block_count calculation
  logic      calc_req;
  logic      div_start;
  logic      div_busy;
  cfg_word_t eff_len;
  cfg_word_t eff_bs;
  cfg_word_t block_count;
  cfg_word_t block_rem;

  // frame state
  logic [CW-1:0] load_count;
  logic [CW-1:0] fetch_count;
  logic [CW-1:0] outer_index;
  logic [CW-1:0] inner_index;
  logic [CW-1:0] scatter;       // buffer address of the next in-span load
  logic [CW-1:0] len;
  logic [CW-1:0] span;          // block_count * eff_bs
  cfg_word_t     row_len;
  cfg_word_t     stride;

  // output register
  logic    ov;
  logic    olast;
  status_t ostatus;

  logic                  accept;
  logic                  is_load;
  logic                  in_span;
  logic                  frame_full;
  logic                  fetch_last;
  logic [XW-1:0]         inner_inc;
  logic [XW-1:0]         outer_inc;
  logic [XW-1:0]         scatter_step;
  logic                  row_wrap;
  logic                  buf_we;
  logic                  buf_re;
  logic [AW-1:0]         buf_waddr;
  logic [DATA_WIDTH-1:0] buf_q;

  // register writes beyond the list are dropped and do not restart the frame
  always_comb begin
    case (cfg_index)
      REG_FRAME_LENGTH: cfg_hit = cfg_we;
      REG_BLOCK_SIZE:   cfg_hit = cfg_we;
      REG_DIRECTION:    cfg_hit = cfg_we;
      default:          cfg_hit = 1'b0;
    endcase
  end

  // zero length acts as one, oversize length clamps to the buffer depth
  always_comb begin
    if (frame_length == '0) begin
      eff_len = CFG_W'(1);
    end else if (int'(frame_length) > MAX_ITEMS) begin
      eff_len = CFG_W'(MAX_ITEMS);
    end else begin
      eff_len = frame_length;
    end
    eff_bs = (row_size == '0) ? CFG_W'(1) : row_size;
  end

  assign div_start = calc_req && !div_busy;

  rci_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (eff_len),
    .divisor  (eff_bs),
    .busy     (div_busy),
    .quot     (block_count),
    .rem      (block_rem)
  );

  // span is the length less its remainder, no multiply needed
  always_comb begin
    len     = CW'(eff_len);
    span    = len - CW'(block_rem);
    row_len = (direction == DIR_DEINTERLEAVE) ? block_count : eff_bs;
    stride  = (direction == DIR_DEINTERLEAVE) ? eff_bs : block_count;
  end

  // no word is taken in the cycle of a register write
  assign items.ready = !calc_req && !div_busy && !cfg_hit && (!ov || results.ready);
  assign accept      = items.valid && items.ready;
  assign is_load     = (items.op == OP_LOAD);

  // address generation: step by stride along a row, back to the next column at the wrap
  always_comb begin
    in_span      = (load_count < span);
    frame_full   = (load_count >= len);
    fetch_last   = ((XW'(fetch_count) + XW'(1)) >= XW'(len));
    inner_inc    = XW'(inner_index) + XW'(1);
    outer_inc    = XW'(outer_index) + XW'(1);
    scatter_step = XW'(scatter) + XW'(stride);
    row_wrap     = (inner_inc >= XW'(row_len));
    buf_waddr    = in_span ? scatter[AW-1:0] : load_count[AW-1:0];
    buf_we       = accept && is_load && !frame_full;
    buf_re       = accept && !is_load && frame_full;
  end

  rci_buf #(
    .AW (AW),
    .DW (DATA_WIDTH)
  ) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (DATA_WIDTH'(items.sample)),
    .re    (buf_re),
    .raddr (fetch_count[AW-1:0]),
    .q     (buf_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= RST_FRAME_LENGTH;
      row_size     <= RST_BLOCK_SIZE;
      direction    <= DIR_INTERLEAVE;
      calc_req     <= 1'b1;
      load_count   <= '0;
      fetch_count  <= '0;
      outer_index  <= '0;
      inner_index  <= '0;
      scatter      <= '0;
      ov           <= 1'b0;
      olast        <= 1'b0;
      ostatus      <= ST_OK;
    end else begin
      if (cfg_hit) begin
        calc_req <= 1'b1;
      end else if (div_start) begin
        calc_req <= 1'b0;
      end

      // fetches and rejected loads fill the output register, a taken word empties it
      if (accept && (!is_load || frame_full)) begin
        ov <= 1'b1;
      end else if (results.valid && results.ready) begin
        ov <= 1'b0;
      end

      if (cfg_hit) begin
        case (cfg_index)
          REG_FRAME_LENGTH: frame_length <= cfg_data;
          REG_BLOCK_SIZE:   row_size     <= cfg_data;
          default:          direction    <= cfg_data[0];
        endcase
        load_count  <= '0;
        fetch_count <= '0;
        outer_index <= '0;
        inner_index <= '0;
        scatter     <= '0;
      end else if (accept) begin
        if (is_load) begin
          if (frame_full) begin
            // load into a full frame: error word, nothing moves
            olast   <= 1'b0;
            ostatus <= ST_FULL;
          end else begin
            load_count <= load_count + CW'(1);
            if (in_span) begin
              if (row_wrap) begin
                inner_index <= '0;
                outer_index <= CW'(outer_inc);
                scatter     <= CW'(outer_inc);
              end else begin
                inner_index <= CW'(inner_inc);
                scatter     <= CW'(scatter_step);
              end
            end
          end
        end else begin
          if (!frame_full) begin
            // fetch before the frame is complete
            olast   <= 1'b0;
            ostatus <= ST_NOT_FULL;
          end else begin
            olast   <= fetch_last;
            ostatus <= ST_OK;
            if (fetch_last) begin
              // last word out: next frame starts
              load_count  <= '0;
              fetch_count <= '0;
              outer_index <= '0;
              inner_index <= '0;
              scatter     <= '0;
            end else begin
              fetch_count <= fetch_count + CW'(1);
            end
          end
        end
      end
    end
  end

  // error words carry zero data
  assign results.valid    = ov;
  assign results.last     = olast;
  assign results.status   = ostatus;
  assign results.data_out = (ostatus == ST_OK) ? OUT_W'(buf_q) : '0;

  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    load_count <= len)
    else $error("load count ran past the frame length");

  a_fetch_full: assert property (@(posedge clk) disable iff (rst)
    (fetch_count != '0) |-> (load_count == len))
    else $error("fetch pointer moved on an incomplete frame");

  a_scatter_span: assert property (@(posedge clk) disable iff (rst)
    (load_count < span) |-> (scatter < span))
    else $error("scatter address left the permuted span");

  a_fetch_word: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_load && frame_full) |=> (results.valid && results.status == ST_OK))
    else $error("accepted fetch did not produce a good word");

endmodule

// ===== tb/sv/tb_row_column_block_interleaver.sv =====
`timescale 1ns / 100ps

module tb_row_column_block_interleaver;
  import rci_pkg::*;

  localparam int DEPTH        = DEF_MAX_ITEMS;
  localparam int DW           = DEF_DATA_WIDTH;
  localparam int RANDOM_WORDS = 600;
  localparam int SETTLE       = 4;     // result is registered after its word; the rest is spare
  localparam int DRAIN        = 8;
  localparam int HOLD_CYCLES  = 400;   // long receiver stall, fills the block
  localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake before giving up
  localparam cfg_idx_t REG_SPARE = 2'd3;  // beyond the register list, must be ignored

  typedef struct packed {
    logic                op;
    logic [SAMPLE_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [OUT_W-1:0] data;
    logic             last;
    status_t          status;
  } out_word_t;

  logic      clk;
  logic      rst;
  logic      cfg_we    = 1'b0;
  cfg_idx_t  cfg_index = '0;
  cfg_word_t cfg_data  = '0;

  rci_in_if  items_if ();
  rci_out_if results_if ();

  row_column_block_interleaver #(
    .MAX_ITEMS (DEPTH),
    .DATA_WIDTH(DW)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .items    (items_if),
    .results  (results_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // words waiting to go in, and results the block owes us
  in_word_t  words_to_send [$];
  out_word_t expected_words [$];

  int error_count = 0;

  // idling knobs, set by the stimulus at negedge
  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;

  // receiver hold-off requests: stimulus bumps hold_asks, monitor serves them
  int hold_asks = 0;
  int hold_done = 0;
  int hold_left = 0;

  // ---------------------------------------------------------------------------
  // Reorder predictor: shadow registers, counters and a copy of the frame buffer
  // ---------------------------------------------------------------------------
  logic [DW-1:0] frame_copy [DEPTH];
  cfg_word_t     len_reg;
  cfg_word_t     bs_reg;
  logic          dir_reg;
  int unsigned   n_loaded;
  int unsigned   n_fetched;
  int unsigned   row_idx;    // outer counter
  int unsigned   col_idx;    // inner counter, wraps at the row length
  int unsigned   n_blocks;

  // length 0 behaves as 1, anything past the buffer as a full buffer
  function automatic int unsigned frame_words();
    if (len_reg == 0) return 1;
    if (len_reg > DEPTH) return DEPTH;
    return len_reg;
  endfunction

  function automatic int unsigned row_words();
    return (bs_reg == 0) ? 1 : bs_reg;
  endfunction

  function automatic void restart_frame();
    n_loaded  = 0;
    n_fetched = 0;
    row_idx   = 0;
    col_idx   = 0;
    n_blocks  = frame_words() / row_words();
  endfunction

  // every write to a listed register restarts the frame; spare index is a no-op
  function automatic void apply_reg(cfg_idx_t idx, cfg_word_t val);
    case (idx)
      REG_FRAME_LENGTH: begin
        len_reg = val;
        restart_frame();
      end
      REG_BLOCK_SIZE: begin
        bs_reg = val;
        restart_frame();
      end
      REG_DIRECTION: begin
        dir_reg = val[0];
        restart_frame();
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_reorder(logic op, logic [SAMPLE_W-1:0] sample);
    int unsigned len, span, row_len, stride, addr;
    out_word_t   res;
    len     = frame_words();
    span    = n_blocks * row_words();   // elements past span stay in place
    row_len = dir_reg ? n_blocks : row_words();
    stride  = dir_reg ? row_words() : n_blocks;
    res     = '0;
    if (op == OP_LOAD) begin
      if (n_loaded >= len) begin
        // frame already full: error word, nothing changes
        res.status = ST_FULL;
        expected_words.push_back(res);
      end else begin
        addr = (n_loaded < span) ? col_idx * stride + row_idx : n_loaded;
        frame_copy[addr % DEPTH] = sample[DW-1:0];
        n_loaded++;
        if (n_loaded < span) begin
          col_idx++;
          if (col_idx >= row_len) begin
            col_idx = 0;
            row_idx++;
          end
        end
      end
    end else if (n_loaded < len) begin
      // frame not complete yet
      res.status = ST_NOT_FULL;
      expected_words.push_back(res);
    end else begin
      res.data   = frame_copy[n_fetched % DEPTH];
      res.status = ST_OK;
      if (n_fetched + 1 >= len) begin
        res.last = 1'b1;
        restart_frame();
      end else begin
        n_fetched++;
      end
      expected_words.push_back(res);
    end
  endfunction

  task automatic flag_error(string msg);
    $display("%0t ERROR %s", $time, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Input driver: feeds words_to_send, predicts each word on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : item_drv
    in_word_t nxt;
    if (rst) begin
      items_if.valid  <= 1'b0;
      items_if.op     <= OP_LOAD;
      items_if.sample <= '0;
    end else begin
      if (items_if.valid && items_if.ready) begin
        predict_reorder(items_if.op, items_if.sample);
      end
      // current word gone (or none offered): offer the next one unless idling
      if (!items_if.valid || items_if.ready) begin
        if (words_to_send.size() != 0 && !(src_idle_en && $urandom_range(99) < 6)) begin
          nxt = words_to_send.pop_front();
          items_if.valid  <= 1'b1;
          items_if.op     <= nxt.op;
          items_if.sample <= nxt.sample;
        end else begin
          items_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks against the oldest expectation, drives ready
  // ---------------------------------------------------------------------------
  int unsigned result_count = 0;

  always @(posedge clk) begin : result_mon
    out_word_t got, want;
    if (rst) begin
      results_if.ready <= 1'b0;
    end else begin
      if (results_if.valid && results_if.ready) begin
        got.data   = results_if.data_out;
        got.last   = results_if.last;
        got.status = results_if.status;
        result_count++;
        if (expected_words.size() == 0) begin
          flag_error($sformatf("result %0d: unexpected word %h/%b/%0d", result_count,
                               got.data, got.last, got.status));
        end else begin
          want = expected_words.pop_front();
          if (got.data !== want.data)
            flag_error($sformatf("result %0d: data_out %h, want %h", result_count,
                                 got.data, want.data));
          if (got.last !== want.last)
            flag_error($sformatf("result %0d: last %b, want %b", result_count,
                                 got.last, want.last));
          if (got.status !== want.status)
            flag_error($sformatf("result %0d: status %0d, want %0d", result_count,
                                 got.status, want.status));
        end
      end
      // ready: long hold-off on request, else random idling
      if (hold_left > 0) begin
        results_if.ready <= 1'b0;
        hold_left        <= hold_left - 1;
      end else if (hold_asks != hold_done) begin
        results_if.ready <= 1'b0;
        hold_left        <= HOLD_CYCLES - 1;
        hold_done        <= hold_done + 1;
      end else begin
        results_if.ready <= !(sink_idle_en && $urandom_range(99) < 6);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run after too long without any handshake
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (items_if.valid && items_if.ready) ||
          (results_if.valid && results_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_row_column_block_interleaver: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_word(logic op, logic [SAMPLE_W-1:0] sample);
    in_word_t w;
    w.op     = op;
    w.sample = sample;
    words_to_send.push_back(w);
  endfunction

  function automatic logic [SAMPLE_W-1:0] any_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // all words in, all results out, then a few cycles for trailing loads
  task automatic wait_quiet();
    while (words_to_send.size() != 0 || items_if.valid || expected_words.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_word_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    apply_reg(idx, val);
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // all = write every register; else a random subset (at least one write)
  task automatic configure(cfg_word_t len, cfg_word_t bs, logic dir, bit all);
    bit        any;
    cfg_word_t dv;
    any   = 1'b0;
    dv    = cfg_word_t'($urandom);   // junk in the upper bits of direction
    dv[0] = dir;
    if (all || $urandom_range(99) < 70) begin
      write_reg(REG_FRAME_LENGTH, len);
      any = 1'b1;
    end
    if (all || $urandom_range(99) < 70) begin
      write_reg(REG_BLOCK_SIZE, bs);
      any = 1'b1;
    end
    if (all || !any || $urandom_range(99) < 70) write_reg(REG_DIRECTION, dv);
    end_writes();
  endtask

  // One frame: loads then fetches, with stray wrong-op words, an occasional
  // spare-register write once full, and sometimes cut short.
  task automatic run_frame(output bit broken, inout int unsigned sent);
    int unsigned len, cut;
    len    = frame_words();
    broken = ($urandom_range(99) < 8);
    cut    = $urandom_range(2 * len - 1);
    for (int unsigned i = 0; i < 2 * len && !(broken && i == cut); i++) begin
      if (i == len && $urandom_range(99) < 15) begin
        wait_quiet();
        write_reg(REG_SPARE, cfg_word_t'($urandom));
        end_writes();
      end
      if ($urandom_range(99) < 5) begin
        queue_word((i < len) ? OP_FETCH : OP_LOAD, any_sample());
        sent++;
      end
      queue_word((i < len) ? OP_LOAD : OP_FETCH, any_sample());
      sent++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned sent, phase, nframes;
    bit          broken;
    cfg_word_t   len, bs;
    rst                = 1'b1;
    len_reg            = RST_FRAME_LENGTH;
    bs_reg             = RST_BLOCK_SIZE;
    dir_reg            = DIR_INTERLEAVE;
    restart_frame();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed ---
    // fetch straight after reset: frame not complete
    queue_word(OP_FETCH, '1);
    wait_quiet();

    // 5 words, blocks of 2: two full blocks plus one word passed through in place
    configure(13'd5, 13'd2, DIR_INTERLEAVE, 1'b1);
    queue_word(OP_LOAD, 32'h0000_0000);
    queue_word(OP_LOAD, 32'hFFFF_FFFF);
    queue_word(OP_LOAD, 32'hAAAA_AAAA);
    queue_word(OP_FETCH, '0);               // early fetch
    queue_word(OP_LOAD, 32'h5555_5555);
    queue_word(OP_LOAD, 32'h8000_0001);
    queue_word(OP_LOAD, 32'h1234_5678);     // frame full: rejected
    for (int unsigned i = 0; i < 5; i++) queue_word(OP_FETCH, '0);
    wait_quiet();

    configure(13'd5, 13'd2, DIR_DEINTERLEAVE, 1'b1);
    for (int unsigned i = 0; i < 5; i++) queue_word(OP_LOAD, 32'hC0DE_0000 | i);
    for (int unsigned i = 0; i < 5; i++) queue_word(OP_FETCH, '1);
    wait_quiet();

    // --- length above the buffer (clamped): a short load leaves the frame open ---
    configure(13'd8191, 13'd64, DIR_DEINTERLEAVE, 1'b1);
    for (int unsigned i = 0; i < 40; i++) queue_word(OP_LOAD, any_sample());
    for (int unsigned i = 0; i < 8; i++) queue_word(OP_FETCH, any_sample());
    wait_quiet();

    // --- mid-size frame, receiver stall while the fetches pile up ---
    configure(13'd96, 13'd8, DIR_DEINTERLEAVE, 1'b1);
    for (int unsigned i = 0; i < 96; i++) queue_word(OP_LOAD, any_sample());
    wait_quiet();
    for (int unsigned i = 0; i < 96; i++) queue_word(OP_FETCH, any_sample());
    @(posedge clk);
    hold_asks <= hold_asks + 1;
    @(negedge clk);
    wait_quiet();

    // --- random phases; the first few pin the corner settings ---
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      // a stretch of phases with no idling on either side
      src_idle_en  = (phase < 9 || phase > 12);
      sink_idle_en = src_idle_en;
      case (phase)
        0: configure(13'd1, 13'd1, DIR_INTERLEAVE, 1'b1);
        1: configure(13'd0, 13'd0, DIR_DEINTERLEAVE, 1'b1);     // both act as 1
        2: configure(13'd7, 13'd4096, DIR_INTERLEAVE, 1'b1);    // no full block
        3: configure(13'd16, 13'd8191, DIR_DEINTERLEAVE, 1'b1);
        4: configure(13'd12, 13'd12, DIR_DEINTERLEAVE, 1'b1);   // one block
        5: configure(13'd12, 13'd1, DIR_INTERLEAVE, 1'b1);
        6: configure(13'd30, 13'd4, DIR_DEINTERLEAVE, 1'b1);
        default: begin
          len = cfg_word_t'(($urandom_range(9) == 0) ? $urandom_range(300, 49)
                                                     : $urandom_range(48, 1));
          bs  = cfg_word_t'($urandom_range(32'(len) + 2));
          configure(len, bs, 1'($urandom_range(1)), 1'b0);
        end
      endcase
      nframes = $urandom_range(3, 1);
      broken  = 1'b0;
      for (int unsigned f = 0; f < nframes && !broken; f++) run_frame(broken, sent);
      wait_quiet();
      phase++;
    end

    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    wait_quiet();
    repeat (DRAIN) @(negedge clk);
    if (error_count == 0)
      $display("tb_row_column_block_interleaver: done, clean");
    else
      $display("tb_row_column_block_interleaver: done, errors");
    $finish;
  end

endmodule
